[rtl/http_port_packet_classifier_core_assert.svh]
// Assertion macros used by the classifier core RTL.
// Each macro expects clk_i and rst_ni to be visible at the point of use.
`ifndef HTTP_PORT_PACKET_CLASSIFIER_CORE_ASSERT_SVH
`define HTTP_PORT_PACKET_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define HPPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define HPPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hppc_pkg.sv]
package hppc_pkg;

  // Widths of the frame counter and of the header offsets.
  localparam int unsigned LenW   = 14;
  localparam int unsigned OfsW   = 7;

  // The byte count stops here.
  localparam logic [LenW-1:0] LEN_CAP = 14'd16383;

  // Fixed byte offsets inside the frame, counted from the destination MAC.
  localparam logic [LenW-1:0] OFS_ETYPE_HI = 14'd12;
  localparam logic [LenW-1:0] OFS_ETYPE_LO = 14'd13;
  localparam logic [LenW-1:0] OFS_IHL      = 14'd14;
  localparam logic [LenW-1:0] OFS_PROTO    = 14'd23;

  // Start of the IPv4 header and TCP header length used by the length check.
  localparam logic [OfsW-1:0] OFS_IP_START = 7'd14;
  localparam logic [OfsW-1:0] TCP_HDR_MIN  = 7'd20;

  // Header values that qualify a frame.
  localparam logic [15:0]     ETH_IPV4     = 16'h0800;
  localparam logic [7:0]      PROTO_TCP    = 8'd6;
  localparam logic [LenW-1:0] MIN_IP_FRAME = 14'd34;
  localparam logic [15:0]     PORT_DEFAULT = 16'd80;

  // Header fields of the current frame, including the byte being taken now.
  typedef struct packed {
    logic [LenW-1:0] length;
    logic [15:0]     ether_kind;
    logic [3:0]      header_words;
    logic [7:0]      ip_protocol;
    logic [15:0]     source_port;
    logic [15:0]     dest_port;
  } hppc_frame_t;

  // Offset of the TCP header for a given IPv4 header length in words.
  function automatic logic [OfsW-1:0] tcp_offset(input logic [3:0] words);
    tcp_offset = OFS_IP_START + {1'b0, words, 2'b00};
  endfunction

endpackage

[rtl/hppc_frame_parser.sv]
module hppc_frame_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  output hppc_pkg::hppc_frame_t frame_o
);
  import hppc_pkg::*;

  logic [LenW-1:0] pos_q;
  logic [15:0]     ether_kind_q;
  logic [3:0]      header_words_q;
  logic [7:0]      ip_protocol_q;
  logic [15:0]     source_port_q;
  logic [15:0]     dest_port_q;

  logic            in_range;
  logic [3:0]      words;
  logic [OfsW-1:0] tcp_ofs;
  logic [LenW-1:0] tcp_ofs_ext;

  // Capture the header bytes that fall on the current position.
  always_comb begin
    in_range    = (pos_q != LEN_CAP);
    words       = (pos_q == OFS_IHL) ? data_byte_i[3:0] : header_words_q;
    tcp_ofs     = tcp_offset(words);
    tcp_ofs_ext = {{(LenW-OfsW){1'b0}}, tcp_ofs};

    frame_o.length       = pos_q;
    frame_o.ether_kind   = ether_kind_q;
    frame_o.header_words = header_words_q;
    frame_o.ip_protocol  = ip_protocol_q;
    frame_o.source_port  = source_port_q;
    frame_o.dest_port    = dest_port_q;

    if (in_range) begin
      frame_o.length       = pos_q + 14'd1;
      frame_o.header_words = words;
      if (pos_q == OFS_ETYPE_HI) frame_o.ether_kind[15:8] = data_byte_i;
      if (pos_q == OFS_ETYPE_LO) frame_o.ether_kind[7:0]  = data_byte_i;
      if (pos_q == OFS_PROTO)    frame_o.ip_protocol      = data_byte_i;
      if (pos_q == tcp_ofs_ext)          frame_o.source_port[15:8] = data_byte_i;
      if (pos_q == tcp_ofs_ext + 14'd1)  frame_o.source_port[7:0]  = data_byte_i;
      if (pos_q == tcp_ofs_ext + 14'd2)  frame_o.dest_port[15:8]   = data_byte_i;
      if (pos_q == tcp_ofs_ext + 14'd3)  frame_o.dest_port[7:0]    = data_byte_i;
    end
  end

  // Per-frame state: updated on every transfer, cleared after the last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q          <= '0;
      ether_kind_q   <= '0;
      header_words_q <= '0;
      ip_protocol_q  <= '0;
      source_port_q  <= '0;
      dest_port_q    <= '0;
    end else if (advance_i) begin
      if (last_byte_i) begin
        pos_q          <= '0;
        ether_kind_q   <= '0;
        header_words_q <= '0;
        ip_protocol_q  <= '0;
        source_port_q  <= '0;
        dest_port_q    <= '0;
      end else begin
        pos_q          <= frame_o.length;
        ether_kind_q   <= frame_o.ether_kind;
        header_words_q <= frame_o.header_words;
        ip_protocol_q  <= frame_o.ip_protocol;
        source_port_q  <= frame_o.source_port;
        dest_port_q    <= frame_o.dest_port;
      end
    end
  end

endmodule

[rtl/http_port_packet_classifier_core.sv]
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+------------------------------------------
// in       | input     | in_valid_i/ready_o  | data_byte_i, last_byte_i
// out      | output    | out_valid_o/ready_i | matched_o, frame_length_o, stored_length_o
// config   | input     | watched_port_we_i   | watched_port_i
//
// One byte transfers per clock save a stalled last byte; a frame's result is registered
// as its last byte leaves the single input register that feeds the parser state.
// Reset clears the frame state, the stored match length, and sets the port to 80.
// While a result waits, non-last bytes still move on; a last byte waits in the input
// register for a free result slot, and input stalls behind it.
`include "http_port_packet_classifier_core_assert.svh"

module http_port_packet_classifier_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        matched_o,
  output logic [13:0] frame_length_o,
  output logic [13:0] stored_length_o,
  input  logic        watched_port_we_i,
  input  logic [15:0] watched_port_i
);
  import hppc_pkg::*;

  logic            in_valid_q;
  logic [7:0]      in_data_q;
  logic            in_last_q;
  logic            out_valid_q;
  logic            matched_q;
  logic [LenW-1:0] frame_len_q;
  logic [LenW-1:0] stored_len_q;
  logic [LenW-1:0] latest_len_q;
  logic [LenW-1:0] latest_len_d;
  logic [15:0]     watched_q;

  logic            out_free;
  logic            advance;
  logic            emit;
  logic            hit;
  logic [OfsW-1:0] hdr_end;
  hppc_frame_t     frame;

  // Handshake: non-last bytes always move on, a last byte needs a free result slot.
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && (!in_last_q || out_free);
  assign emit       = advance && in_last_q;
  assign in_ready_o = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  hppc_frame_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .data_byte_i (in_data_q),
    .last_byte_i (in_last_q),
    .frame_o     (frame)
  );

  // Match decision over the completed frame headers.
  always_comb begin
    hdr_end = tcp_offset(frame.header_words) + TCP_HDR_MIN;
    hit = (frame.ether_kind == ETH_IPV4) && (frame.ip_protocol == PROTO_TCP) &&
          (frame.length >= MIN_IP_FRAME) &&
          (frame.length >= {{(LenW-OfsW){1'b0}}, hdr_end}) &&
          ((frame.source_port == watched_q) || (frame.dest_port == watched_q));
    latest_len_d = hit ? frame.length : latest_len_q;
  end

  // Configuration register and stored match length.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      watched_q    <= PORT_DEFAULT;
      latest_len_q <= '0;
    end else begin
      if (watched_port_we_i) watched_q <= watched_port_i;
      if (emit) latest_len_q <= latest_len_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      matched_q    <= hit;
      frame_len_q  <= frame.length;
      stored_len_q <= latest_len_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign matched_o       = matched_q;
  assign frame_length_o  = frame_len_q;
  assign stored_length_o = stored_len_q;

  // A matched frame stores its own length.
  `HPPC_ASSERT_NOW(a_match_stores_len, out_valid_q && matched_q,
    stored_len_q == frame_len_q, "matched frame did not store its length")

  // A matched frame holds at least the Ethernet and IPv4 headers.
  `HPPC_ASSERT_NOW(a_match_min_len, out_valid_q && matched_q,
    frame_len_q >= MIN_IP_FRAME, "matched frame shorter than minimum")

  // Every reported frame counts at least its last byte.
  `HPPC_ASSERT_NOW(a_len_nonzero, out_valid_q, frame_len_q != '0,
    "reported frame length is zero")

  // A last byte waiting on a full result slot stays in the input register.
  `HPPC_ASSERT_NEXT(a_last_held, in_valid_q && in_last_q && out_valid_q && !out_ready_i,
    in_valid_q && in_last_q, "last byte dropped while result stalled")

endmodule
